@@ rtl/stc_pkg.sv @@
// Shared types and constants for the spanning tree counter.
// Used by the front end, the elimination engine and the top level.
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

   localparam int ROWS    = 16;
   localparam int IDX_W   = 4;
   localparam int VAL_W   = 64;
   localparam int PROD_W  = 128;
   localparam int COUNT_W = 56;
   localparam int VCNT_W  = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [IDX_W-1:0]             last_idx;
      logic [ROWS-1:0][ROWS-1:0]    adj;
   } job_type;

   typedef struct packed {
      logic [COUNT_W-1:0] tree_count;
      logic               disconnected;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/spanning_tree_counter.sv @@
// Top level of the spanning tree counter: configuration register, front end,
// graph queue, elimination engine and result queue. Depends on stc_pkg.
//
//   Channel   Ports                                          Direction
//   request   push, full, req_adjacency_row, req_last_row    in
//   response  empty, pop, rsp_tree_count, rsp_disconnected   out
//   config    csr_write_en, csr_vertex_count                 in
//
// Rows stream back to back while full is low. After the last row the
// engine builds the minor, then eliminates it cell by cell with a
// bit-serial 128-bit divider. Reset is synchronous; no clearing pass
// follows it. full rises while two graphs wait for the engine, and the
// engine stalls while two results wait.
`timescale 1ns / 1ps
`default_nettype none

module spanning_tree_counter #(
   parameter int MAX_VERTICES = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   output logic                                full,
   input  wire logic [15:0]                    req_adjacency_row,
   input  wire logic                           req_last_row,
   output logic                                empty,
   input  wire logic                           pop,
   output logic [stc_pkg::COUNT_W-1:0]         rsp_tree_count,
   output logic                                rsp_disconnected,
   input  wire logic                           csr_write_en,
   input  wire logic [stc_pkg::VCNT_W-1:0]     csr_vertex_count
);

   import stc_pkg::*;

   logic [VCNT_W-1:0] vertex_count_ff;
   job_type           front_job, engine_job;
   logic              job_push, job_full, job_pop, job_empty;
   result_type        engine_res, out_res;
   logic              res_push, res_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VCNT_W'(16);
      end else if (csr_write_en) begin
         vertex_count_ff <= csr_vertex_count;
      end
   end

   stc_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .vertex_count  (vertex_count_ff),
      .push          (push),
      .full          (full),
      .adjacency_row (req_adjacency_row),
      .last_row      (req_last_row),
      .job_push      (job_push),
      .job           (front_job),
      .job_full      (job_full)
   );

   stc_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (2)
   ) u_job_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (front_job),
      .full    (job_full),
      .pop     (job_pop),
      .rd_data (engine_job),
      .empty   (job_empty)
   );

   stc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (engine_job),
      .job_pop   (job_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (engine_res)
   );

   stc_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (2)
   ) u_res_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (engine_res),
      .full    (res_full),
      .pop     (pop),
      .rd_data (out_res),
      .empty   (empty)
   );

   assign rsp_tree_count   = out_res.tree_count;
   assign rsp_disconnected = out_res.disconnected;

endmodule

`default_nettype wire

@@ rtl/stc_fifo.sv @@
// Small synchronous queue used between front end, engine and result port.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module stc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/stc_front.sv @@
// Front end: loads adjacency rows and hands a finished graph to the engine.
// Depends on stc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stc_front #(
   parameter int MAX_VERTICES = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [stc_pkg::VCNT_W-1:0]   vertex_count,
   input  wire logic                         push,
   output logic                              full,
   input  wire logic [stc_pkg::ROWS-1:0]     adjacency_row,
   input  wire logic                         last_row,
   output logic                              job_push,
   output stc_pkg::job_type                  job,
   input  wire logic                         job_full
);

   import stc_pkg::*;

   logic [ROWS-1:0]   rows_ff [MAX_VERTICES];
   logic [VCNT_W-1:0] rows_loaded_ff, rows_loaded_in;
   logic [VCNT_W-1:0] n_eff;
   logic              accept, load;

   always_comb begin
      if (vertex_count == '0) begin
         n_eff = VCNT_W'(1);
      end else if (vertex_count > VCNT_W'(MAX_VERTICES)) begin
         n_eff = VCNT_W'(MAX_VERTICES);
      end else begin
         n_eff = vertex_count;
      end
   end

   assign full     = job_full;
   assign accept   = push && !job_full;
   assign load     = accept && (rows_loaded_ff < n_eff);
   assign job_push = accept && last_row;

   always_comb begin
      job.last_idx = IDX_W'(n_eff - 1'b1);
      for (int r = 0; r < ROWS; r++) begin
         if (r < MAX_VERTICES && VCNT_W'(r) < rows_loaded_ff) begin
            job.adj[r] = rows_ff[r];
         end else if (VCNT_W'(r) == rows_loaded_ff && load) begin
            job.adj[r] = adjacency_row;
         end else begin
            job.adj[r] = '0;
         end
      end
   end

   always_comb begin
      rows_loaded_in = rows_loaded_ff;
      if (job_push) begin
         rows_loaded_in = '0;
      end else if (load) begin
         rows_loaded_in = rows_loaded_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_loaded_ff <= '0;
      end else begin
         rows_loaded_ff <= rows_loaded_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
         if (load && rows_loaded_ff == VCNT_W'(r)) begin
            rows_ff[r] <= adjacency_row;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/stc_engine.sv @@
// Back end: builds the Laplacian minor and runs fraction-free elimination.
// Depends on stc_pkg; holds the work matrix memory and a bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none

module stc_engine (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          job_empty,
   input  stc_pkg::job_type   job,
   output logic               job_pop,
   input  wire logic          res_full,
   output logic               res_push,
   output stc_pkg::result_type res
);

   import stc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_PRD, ST_PCHK, ST_CRD, ST_CLAT, ST_RD, ST_LAT,
      ST_MUL, ST_ACC, ST_DPREP, ST_DIV, ST_WR, ST_OUT
   } state_type;

   logic [VAL_W-1:0] mem [ROWS*ROWS];

   state_type                 state_ff, state_in;
   logic [ROWS-1:0][ROWS-1:0] adj_ff, adj_in;
   logic [IDX_W-1:0]          m_ff, m_in, k_ff, k_in, i_ff, i_in;
   logic [IDX_W-1:0]          j_ff, j_in, r_ff, r_in;
   logic [IDX_W-1:0]          perm_ff [ROWS];
   logic [IDX_W-1:0]          perm_in [ROWS];
   logic [VAL_W-1:0]          piv_mag_ff, piv_mag_in;
   logic                      piv_neg_ff, piv_neg_in;
   logic [VAL_W-1:0]          prev_mag_ff, prev_mag_in;
   logic                      prev_neg_ff, prev_neg_in;
   logic [VAL_W-1:0]          c_mag_ff, c_mag_in, b_mag_ff, b_mag_in, d_mag_ff, d_mag_in;
   logic                      c_neg_ff, c_neg_in, b_neg_ff, b_neg_in, d_neg_ff, d_neg_in;
   logic [VAL_W-1:0]          pp_ff, pp_in;
   logic [6:0]                sh_ff, sh_in;
   logic [PROD_W-1:0]         acc_ff, acc_in, diff_ff, diff_in, dvd_ff, dvd_in;
   logic [2:0]                mstep_ff, mstep_in;
   logic                      second_ff, second_in;
   logic [VAL_W-1:0]          rem_ff, rem_in, quo_ff, quo_in;
   logic                      qneg_ff, qneg_in;
   logic [6:0]                cnt_ff, cnt_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      disc_ff, disc_in;

   logic [VAL_W-1:0]          rd_a_ff, rd_b_ff;
   logic [2*IDX_W-1:0]        rd_a_addr, rd_b_addr, wr_addr;
   logic [VAL_W-1:0]          wr_data;
   logic                      wr_en;

   function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] v);
      mag = v[VAL_W-1] ? (~v + 1'b1) : v;
   endfunction

   always_comb begin
      unique case (state_ff)
         ST_PRD:  rd_a_addr = {perm_ff[r_ff], k_ff};
         ST_CRD:  rd_a_addr = {perm_ff[i_ff], k_ff};
         default: rd_a_addr = {perm_ff[k_ff], j_ff};
      endcase
      rd_b_addr = {perm_ff[i_ff], j_ff};
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      logic [ROWS-1:0]   row_bits;
      logic [IDX_W:0]    deg;
      logic [31:0]       xs, ys;
      logic [VAL_W-1:0]  xm, ym;
      logic              addflag;
      logic [VAL_W-1:0]  rem2;
      logic [VAL_W-1:0]  piv_abs;

      state_in    = state_ff;
      adj_in      = adj_ff;
      m_in        = m_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      r_in        = r_ff;
      perm_in     = perm_ff;
      piv_mag_in  = piv_mag_ff;
      piv_neg_in  = piv_neg_ff;
      prev_mag_in = prev_mag_ff;
      prev_neg_in = prev_neg_ff;
      c_mag_in    = c_mag_ff;
      c_neg_in    = c_neg_ff;
      b_mag_in    = b_mag_ff;
      b_neg_in    = b_neg_ff;
      d_mag_in    = d_mag_ff;
      d_neg_in    = d_neg_ff;
      pp_in       = pp_ff;
      sh_in       = sh_ff;
      acc_in      = acc_ff;
      diff_in     = diff_ff;
      dvd_in      = dvd_ff;
      mstep_in    = mstep_ff;
      second_in   = second_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      qneg_in     = qneg_ff;
      cnt_in      = cnt_ff;
      count_in    = count_ff;
      disc_in     = disc_ff;
      job_pop     = 1'b0;
      res_push    = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = {perm_ff[i_ff], j_ff};
      wr_data     = '0;

      for (int b = 0; b < ROWS; b++) begin
         row_bits[b] = adj_ff[i_ff][b] && (IDX_W'(b) <= m_ff) && (IDX_W'(b) != i_ff);
      end
      deg = '0;
      for (int b = 0; b < ROWS; b++) begin
         deg = deg + (IDX_W + 1)'(row_bits[b]);
      end

      xm   = second_ff ? c_mag_ff : piv_mag_ff;
      ym   = second_ff ? d_mag_ff : b_mag_ff;
      xs   = mstep_ff[1] ? xm[63:32] : xm[31:0];
      ys   = mstep_ff[0] ? ym[63:32] : ym[31:0];
      addflag = second_ff ? (c_neg_ff ^ d_neg_ff) : !(piv_neg_ff ^ b_neg_ff);
      rem2 = {rem_ff[VAL_W-2:0], dvd_ff[PROD_W-1]};
      piv_abs = mag(rd_a_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               adj_in  = job.adj;
               m_in    = job.last_idx;
               for (int p = 0; p < ROWS; p++) begin
                  perm_in[p] = IDX_W'(p);
               end
               if (job.last_idx == '0) begin
                  count_in = COUNT_W'(1);
                  disc_in  = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  i_in     = IDX_W'(1);
                  j_in     = IDX_W'(1);
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = {i_ff, j_ff};
            if (i_ff == j_ff) begin
               wr_data = VAL_W'(deg);
            end else if (adj_ff[i_ff][j_ff]) begin
               wr_data = '1;
            end else begin
               wr_data = '0;
            end
            if (j_ff != m_ff) begin
               j_in = j_ff + 1'b1;
            end else if (i_ff != m_ff) begin
               i_in = i_ff + 1'b1;
               j_in = IDX_W'(1);
            end else begin
               prev_mag_in = VAL_W'(1);
               prev_neg_in = 1'b0;
               k_in        = IDX_W'(1);
               r_in        = IDX_W'(1);
               state_in    = ST_PRD;
            end
         end
         ST_PRD: begin
            state_in = ST_PCHK;
         end
         ST_PCHK: begin
            if (rd_a_ff != '0) begin
               perm_in[k_ff] = perm_ff[r_ff];
               perm_in[r_ff] = perm_ff[k_ff];
               piv_mag_in    = piv_abs;
               piv_neg_in    = rd_a_ff[VAL_W-1];
               if (k_ff == m_ff) begin
                  count_in = (piv_abs > VAL_W'(COUNT_MAX)) ? COUNT_MAX
                           : piv_abs[COUNT_W-1:0];
                  disc_in  = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  i_in     = k_ff + 1'b1;
                  state_in = ST_CRD;
               end
            end else if (r_ff == m_ff) begin
               count_in = '0;
               disc_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               r_in     = r_ff + 1'b1;
               state_in = ST_PRD;
            end
         end
         ST_CRD: begin
            state_in = ST_CLAT;
         end
         ST_CLAT: begin
            c_mag_in = mag(rd_a_ff);
            c_neg_in = rd_a_ff[VAL_W-1];
            j_in     = k_ff + 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_LAT;
         end
         ST_LAT: begin
            d_mag_in  = mag(rd_a_ff);
            d_neg_in  = rd_a_ff[VAL_W-1];
            b_mag_in  = mag(rd_b_ff);
            b_neg_in  = rd_b_ff[VAL_W-1];
            second_in = 1'b0;
            mstep_in  = '0;
            acc_in    = '0;
            diff_in   = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mstep_ff != 3'd4) begin
               pp_in = xs * ys;
               sh_in = {1'b0, mstep_ff[1], 5'd0} + {1'b0, mstep_ff[0], 5'd0};
            end
            if (mstep_ff != '0) begin
               acc_in = acc_ff + ({{(PROD_W-VAL_W){1'b0}}, pp_ff} << sh_ff);
            end
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 3'd4) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            diff_in  = addflag ? diff_ff + acc_ff : diff_ff - acc_ff;
            acc_in   = '0;
            mstep_in = '0;
            if (!second_ff) begin
               second_in = 1'b1;
               state_in  = ST_MUL;
            end else begin
               state_in = ST_DPREP;
            end
         end
         ST_DPREP: begin
            dvd_in   = diff_ff[PROD_W-1] ? (~diff_ff + 1'b1) : diff_ff;
            qneg_in  = diff_ff[PROD_W-1] ^ prev_neg_ff;
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_ff[VAL_W-1] || rem2 >= prev_mag_ff) begin
               rem_in = rem2 - prev_mag_ff;
               quo_in = {quo_ff[VAL_W-2:0], 1'b1};
            end else begin
               rem_in = rem2;
               quo_in = {quo_ff[VAL_W-2:0], 1'b0};
            end
            dvd_in = {dvd_ff[PROD_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 7'd127) begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            wr_en = 1'b1;
            if (prev_mag_ff == '0) begin
               wr_data = '0;
            end else begin
               wr_data = qneg_ff ? (~quo_ff + 1'b1) : quo_ff;
            end
            if (j_ff != m_ff) begin
               j_in     = j_ff + 1'b1;
               state_in = ST_RD;
            end else if (i_ff != m_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_CRD;
            end else begin
               prev_mag_in = piv_mag_ff;
               prev_neg_in = piv_neg_ff;
               k_in        = k_ff + 1'b1;
               r_in        = k_ff + 1'b1;
               state_in    = ST_PRD;
            end
         end
         ST_OUT: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.tree_count   = count_ff;
   assign res.disconnected = disc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      adj_ff      <= adj_in;
      m_ff        <= m_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      r_ff        <= r_in;
      perm_ff     <= perm_in;
      piv_mag_ff  <= piv_mag_in;
      piv_neg_ff  <= piv_neg_in;
      prev_mag_ff <= prev_mag_in;
      prev_neg_ff <= prev_neg_in;
      c_mag_ff    <= c_mag_in;
      c_neg_ff    <= c_neg_in;
      b_mag_ff    <= b_mag_in;
      b_neg_ff    <= b_neg_in;
      d_mag_ff    <= d_mag_in;
      d_neg_ff    <= d_neg_in;
      pp_ff       <= pp_in;
      sh_ff       <= sh_in;
      acc_ff      <= acc_in;
      diff_ff     <= diff_in;
      dvd_ff      <= dvd_in;
      mstep_ff    <= mstep_in;
      second_ff   <= second_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      qneg_ff     <= qneg_in;
      cnt_ff      <= cnt_in;
      count_ff    <= count_in;
      disc_ff     <= disc_in;
   end

endmodule

`default_nettype wire
